// ----- design/mpp_pkg.sv -----
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared constants, types and the 2^f table for the Morse pair potential.
// ----------------------------------------------------------------------------
package mpp_pkg;

   // fixed field widths
   localparam int DIST_BITS  = 24;
   localparam int PARAM_BITS = 16;
   localparam int RES_BITS   = 32;
   localparam int FRAC_BITS  = 20;

   // exponential table split of the Q.20 fraction
   localparam int EXP_TABLE_BITS = 8;
   localparam int TBL_SIZE       = 1 << EXP_TABLE_BITS;
   localparam int G_BITS         = FRAC_BITS - EXP_TABLE_BITS;
   localparam int H_BITS         = G_BITS + 10;

   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [23:0] ONE_Q20   = 24'h100000;
   localparam int          CLIP_INT  = 12;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RANGE_RHO  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WELL_DEPTH = 2'd1;

   localparam logic [PARAM_BITS-1:0] RHO_RESET   = 16'd6144;
   localparam logic [PARAM_BITS-1:0] DEPTH_RESET = 16'd256;

   typedef logic [30:0] tbl_type [TBL_SIZE];

   // exponential stage result passed to the polynomial stages
   typedef struct packed {
      logic [31:0] y;
      logic        clip;
   } expo_type;

   // restoring quotient, used only while the table is elaborated
   function automatic longint unsigned udiv_const(longint unsigned num,
                                                  longint unsigned den);
      longint unsigned q;
      longint unsigned rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem  = rem - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // 2^(k/TBL_SIZE) in Q.30 by a truncated series of exp(k*ln2/TBL_SIZE)
   function automatic tbl_type build_pow2_tbl();
      tbl_type           t;
      longint unsigned   y;
      longint unsigned   term;
      longint unsigned   sum;
      for (int k = 0; k < TBL_SIZE; k++) begin
         y    = (longint'(k) * longint'(LN2_Q30)) >> EXP_TABLE_BITS;
         term = 64'd1 << 30;
         sum  = 64'd1 << 30;
         for (int i = 1; i <= 20; i++) begin
            term = udiv_const((term * y) >> 30, 64'(i));
            sum  = sum + term;
         end
         t[k] = sum[30:0];
      end
      return t;
   endfunction

   localparam tbl_type POW2_TBL = build_pow2_tbl();

endpackage

// ----- design/mpp_exp.sv -----
// ----------------------------------------------------------------------------
// mpp_exp
// Six-stage pipeline forming Y = exp(-rho*(r-1)) in Q.20 with a clip flag.
// ----------------------------------------------------------------------------
module mpp_exp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [mpp_pkg::DIST_BITS-1:0]    in_distance,
   input  logic [mpp_pkg::PARAM_BITS-1:0]   range_rho,
   output logic                             out_valid,
   input  logic                             out_ready,
   output mpp_pkg::expo_type                out_expo
);
   import mpp_pkg::*;

   localparam int NS = 6;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] en;

   // stall chain: a stage moves when empty or when the next one moves
   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // stage 1: distance from one, times rho
   logic        below_in;
   logic [23:0] d_in;
   logic [39:0] prod1;
   logic        below1_ff;
   logic [29:0] m_ff;

   assign below_in = in_distance < ONE_Q20;
   assign d_in     = below_in ? 24'(ONE_Q20 - in_distance) : 24'(in_distance - ONE_Q20);
   assign prod1    = 40'(d_in) * 40'(range_rho);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         below1_ff <= below_in;
         m_ff      <= prod1[39:10];
      end
   end

   // stage 2: scale by log2(e)
   logic [60:0] prod2;
   logic        below2_ff;
   logic [30:0] p_ff;

   assign prod2 = 61'(m_ff) * 61'(LOG2E_Q30);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         below2_ff <= below1_ff;
         p_ff      <= prod2[60:30];
      end
   end

   // stage 3: integer and fraction split, table lookup, low fraction term
   logic [10:0]          ip;
   logic [19:0]          fp;
   logic [19:0]          f_in;
   logic [11:0]          sh_up;
   logic                 clip_in;
   logic                 zero_in;
   logic                 lsh_in;
   logic [5:0]           rsh_in;
   logic [G_BITS-1:0]    g_in;
   logic [G_BITS+29:0]   prod3;
   logic [30:0]          t3_ff;
   logic [H_BITS-1:0]    h_ff;
   logic                 clip3_ff;
   logic                 zero3_ff;
   logic                 lsh3_ff;
   logic [5:0]           rsh3_ff;

   assign ip      = p_ff[30:20];
   assign fp      = p_ff[19:0];
   assign clip_in = below2_ff && (ip >= 11'(CLIP_INT));
   assign f_in    = below2_ff ? fp : ((fp == '0) ? '0 : 20'(21'h100000 - 21'(fp)));
   assign sh_up   = 12'(ip) + 12'd10 + 12'(fp != '0);
   assign zero_in = !below2_ff && (sh_up >= 12'd64);
   assign lsh_in  = below2_ff && (ip == 11'd11);
   assign rsh_in  = below2_ff ? 6'(4'd10 - ip[3:0]) : sh_up[5:0];
   assign g_in    = f_in[G_BITS-1:0];
   assign prod3   = (G_BITS+30)'(g_in) * (G_BITS+30)'(LN2_Q30);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         t3_ff    <= POW2_TBL[f_in[FRAC_BITS-1 -: EXP_TABLE_BITS]];
         h_ff     <= prod3[G_BITS+29:20];
         clip3_ff <= clip_in;
         zero3_ff <= zero_in;
         lsh3_ff  <= lsh_in;
         rsh3_ff  <= rsh_in;
      end
   end

   // stage 4: second-order correction c = 1 + h + h*h/2
   logic [2*H_BITS-1:0] hh;
   logic [31:0]         c_in;
   logic [31:0]         c_ff;
   logic [30:0]         t4_ff;
   logic                clip4_ff;
   logic                zero4_ff;
   logic                lsh4_ff;
   logic [5:0]          rsh4_ff;

   assign hh   = (2*H_BITS)'(h_ff) * (2*H_BITS)'(h_ff);
   assign c_in = 32'h4000_0000 + 32'(h_ff) + 32'(hh[2*H_BITS-1:31]);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         c_ff     <= c_in;
         t4_ff    <= t3_ff;
         clip4_ff <= clip3_ff;
         zero4_ff <= zero3_ff;
         lsh4_ff  <= lsh3_ff;
         rsh4_ff  <= rsh3_ff;
      end
   end

   // stage 5: mantissa = table value times correction
   logic [62:0] prod5;
   logic [32:0] mant_ff;
   logic        clip5_ff;
   logic        zero5_ff;
   logic        lsh5_ff;
   logic [5:0]  rsh5_ff;

   assign prod5 = 63'(t4_ff) * 63'(c_ff);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         mant_ff  <= prod5[62:30];
         clip5_ff <= clip4_ff;
         zero5_ff <= zero4_ff;
         lsh5_ff  <= lsh4_ff;
         rsh5_ff  <= rsh4_ff;
      end
   end

   // stage 6: apply the integer exponent as a shift
   logic [32:0] shifted;
   logic [31:0] y_in;
   expo_type    expo_ff;

   assign shifted = mant_ff >> rsh5_ff;

   always_comb begin
      if (zero5_ff)     y_in = '0;
      else if (lsh5_ff) y_in = {mant_ff[30:0], 1'b0};
      else              y_in = shifted[31:0];
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         expo_ff.y    <= y_in;
         expo_ff.clip <= clip5_ff;
      end
   end

   assign out_expo = expo_ff;

endmodule

// ----- design/mpp_poly.sv -----
// ----------------------------------------------------------------------------
// mpp_poly
// Five-stage pipeline forming energy and derivative from Y, with saturation.
// ----------------------------------------------------------------------------
module mpp_poly (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  mpp_pkg::expo_type                in_expo,
   input  logic [mpp_pkg::PARAM_BITS-1:0]   range_rho,
   input  logic [mpp_pkg::PARAM_BITS-1:0]   well_depth,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [mpp_pkg::RES_BITS-1:0]     out_energy,
   output logic [mpp_pkg::RES_BITS-1:0]     out_derivative,
   output logic                             out_saturated
);
   import mpp_pkg::*;

   localparam int NS = 5;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] en;

   // stall chain
   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // stage 1: Y squared
   logic [31:0] y_ff;
   logic [63:0] yy_ff;
   logic        clip1_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         y_ff     <= in_expo.y;
         yy_ff    <= 64'(in_expo.y) * 64'(in_expo.y);
         clip1_ff <= in_expo.clip;
      end
   end

   // stage 2: Y*Y - 2Y and Y - Y*Y as sign and magnitude
   logic [63:0] ty;
   logic [63:0] tu;
   logic        neg_t_in;
   logic        neg_u_in;
   logic [63:0] mt_in;
   logic [63:0] mu_in;
   logic        neg_t_ff;
   logic        neg_u_ff;
   logic [47:0] mt_ff;
   logic [47:0] mu_ff;
   logic        clip2_ff;

   assign ty       = {11'b0, y_ff, 21'b0};
   assign tu       = {12'b0, y_ff, 20'b0};
   assign neg_t_in = yy_ff < ty;
   assign neg_u_in = yy_ff > tu;
   assign mt_in    = neg_t_in ? (ty - yy_ff) : (yy_ff - ty);
   assign mu_in    = neg_u_in ? (yy_ff - tu) : (tu - yy_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         neg_t_ff <= neg_t_in;
         neg_u_ff <= neg_u_in;
         mt_ff    <= mt_in[63:16];
         mu_ff    <= mu_in[63:16];
         clip2_ff <= clip1_ff;
      end
   end

   // stage 3: scale both by the well depth
   logic [63:0] pe;
   logic [63:0] pu;
   logic [47:0] em_ff;
   logic [47:0] du_ff;
   logic        neg_t3_ff;
   logic        neg_u3_ff;
   logic        clip3_ff;

   assign pe = 64'(mt_ff) * 64'(well_depth);
   assign pu = 64'(mu_ff) * 64'(well_depth);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         em_ff     <= pe[63:16];
         du_ff     <= pu[63:16];
         neg_t3_ff <= neg_t_ff;
         neg_u3_ff <= neg_u_ff;
         clip3_ff  <= clip2_ff;
      end
   end

   // stage 4: derivative times rho, energy saturation
   logic [63:0] pd;
   logic [31:0] energy_in;
   logic        sat_e_in;
   logic [54:0] dv_ff;
   logic        neg_u4_ff;
   logic        clip4_ff;
   logic [31:0] energy4_ff;
   logic        sat_e4_ff;

   assign pd = 64'(du_ff) * 64'(range_rho);

   always_comb begin
      sat_e_in  = 1'b0;
      energy_in = em_ff[31:0];
      if (neg_t3_ff) begin
         if (em_ff > 48'h0000_8000_0000) begin
            sat_e_in  = 1'b1;
            energy_in = 32'h8000_0000;
         end else begin
            energy_in = 32'(32'd0 - em_ff[31:0]);
         end
      end else if (em_ff > 48'h0000_7FFF_FFFF) begin
         sat_e_in  = 1'b1;
         energy_in = 32'h7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         dv_ff      <= pd[63:9];
         neg_u4_ff  <= neg_u3_ff;
         clip4_ff   <= clip3_ff;
         energy4_ff <= energy_in;
         sat_e4_ff  <= sat_e_in;
      end
   end

   // stage 5: derivative saturation and large-exponential override
   logic [31:0] deriv_in;
   logic        sat_d_in;
   logic        depth_nz;
   logic [31:0] energy_ff;
   logic [31:0] deriv_ff;
   logic        sat_ff;

   assign depth_nz = well_depth != '0;

   always_comb begin
      sat_d_in = 1'b0;
      deriv_in = dv_ff[31:0];
      if (neg_u4_ff) begin
         if (dv_ff > 55'h80000000) begin
            sat_d_in = 1'b1;
            deriv_in = 32'h8000_0000;
         end else begin
            deriv_in = 32'(32'd0 - dv_ff[31:0]);
         end
      end else if (dv_ff > 55'h7FFFFFFF) begin
         sat_d_in = 1'b1;
         deriv_in = 32'h7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         if (clip4_ff) begin
            energy_ff <= depth_nz ? 32'h7FFF_FFFF : 32'h0;
            deriv_ff  <= depth_nz ? 32'h8000_0000 : 32'h0;
            sat_ff    <= 1'b1;
         end else begin
            energy_ff <= energy4_ff;
            deriv_ff  <= deriv_in;
            sat_ff    <= sat_e4_ff || sat_d_in;
         end
      end
   end

   assign out_energy     = energy_ff;
   assign out_derivative = deriv_ff;
   assign out_saturated  = sat_ff;

endmodule

// ----- design/morse_pair_potential.sv -----
// ----------------------------------------------------------------------------
// morse_pair_potential
// Morse energy and radial derivative for one pair distance per beat.
// ----------------------------------------------------------------------------
// A distance beat is accepted every cycle unless a result-side stall has filled
// the pipeline; it passes six stages for the exponential, then five for energy,
// derivative and saturation, at most two multipliers in a stage. Stalls on the
// result side back up stage by stage, so empty stages are filled before the input is held.
// range_rho and well_depth are read live by the pipeline and must be written
// only while no beat is in flight.
module morse_pair_potential (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [mpp_pkg::DIST_BITS-1:0]          req_distance,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [mpp_pkg::RES_BITS-1:0]    rsp_energy,
   output logic signed [mpp_pkg::RES_BITS-1:0]    rsp_derivative,
   output logic                                   rsp_saturated,
   input  logic                                   csr_we,
   input  logic [mpp_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mpp_pkg::PARAM_BITS-1:0]         csr_wdata
);
   import mpp_pkg::*;

   logic [PARAM_BITS-1:0] rho_ff;
   logic [PARAM_BITS-1:0] depth_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rho_ff   <= RHO_RESET;
         depth_ff <= DEPTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RANGE_RHO:  rho_ff   <= csr_wdata;
            REG_WELL_DEPTH: depth_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic     expo_valid;
   logic     expo_ready;
   expo_type expo;
   logic [RES_BITS-1:0] energy;
   logic [RES_BITS-1:0] derivative;

   // exponential front end
   mpp_exp u_exp (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_distance (req_distance),
      .range_rho   (rho_ff),
      .out_valid   (expo_valid),
      .out_ready   (expo_ready),
      .out_expo    (expo)
   );

   // energy and derivative back end
   mpp_poly u_poly (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (expo_valid),
      .in_ready       (expo_ready),
      .in_expo        (expo),
      .range_rho      (rho_ff),
      .well_depth     (depth_ff),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_energy     (energy),
      .out_derivative (derivative),
      .out_saturated  (rsp_saturated)
   );

   assign rsp_energy     = energy;
   assign rsp_derivative = derivative;

endmodule
